FILE: src/rrl_pkg.sv
// Shared constants, codes and controller/datapath types for the ring list.
`default_nettype none
package rrl_pkg;

    // Store geometry
    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // Fixed payload widths of the channels
    localparam int CMD_W   = 3;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 5;

    // Request opcodes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_NEXT   = 3'd4
    } t_cmd;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_NEW,
        ST_ADD_LINK,
        ST_DEL_START,
        ST_DEL_COPY,
        ST_WALK,
        ST_NEXT_STEP,
        ST_FETCH,
        ST_DONE
    } t_state;

    // Datapath update operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_WALK_INIT,
        DP_ADD_NEW,
        DP_ADD_LINK,
        DP_DEL_ONE,
        DP_DEL_GONE,
        DP_DEL_COPY,
        DP_STEP
    } t_dp_op;

    // Read address source
    typedef enum logic {
        RD_CUR,
        RD_LINK
    } t_rd_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    item_load;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_dp_op  op;
        logic    res_load;
        logic    res_ok;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic full;
        logic item_zero;
        logic match;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/rrl_if.sv
// Request and result channel interfaces of the ring list.
`default_nettype none
interface rrl_req_if;
    import rrl_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ITEM_W-1:0] item;

    modport source (output valid, output cmd, output item, input ready);
    modport sink   (input valid, input cmd, input item, output ready);
endinterface

interface rrl_res_if;
    import rrl_pkg::*;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [ITEM_W-1:0]  current_data;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output ok, output current_data, output count, input ready);
    modport sink   (input valid, input ok, input current_data, input count, output ready);
endinterface
`default_nettype wire

FILE: src/round_robin_ring_list.sv
// Top level of the bounded circular list with current position and free slots.
//
//  channel  dir  payload                         accepted when
//  i_req    in   cmd[2:0], item[31:0]            valid & ready
//  o_res    out  ok, current_data[31:0], count   valid & ready
//
// One request at a time. Turned down are a null or full add, a request on an
// empty list, a null remove and a spare opcode. Delete drops a lone entry or
// copies the next entry over the current one. Find or remove compares one
// entry per link until a match or until every entry has been compared; a
// remove that matches then deletes the entry it found, lone or not.
// After reset the list is empty and every slot is free; no clearing pass is
// needed. A new request can be taken in the cycle after the result loads,
// even while that result still waits; a held result stalls only the next
// finish.
`default_nettype none
module round_robin_ring_list
    import rrl_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    rrl_req_if.sink  i_req,
    rrl_res_if.source o_res
);

    t_ctl ctl;
    t_sts sts;

    rrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_cmd   (i_req.cmd),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    rrl_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_item  (i_req.item),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_ok    (o_res.ok),
        .o_data  (o_res.current_data),
        .o_count (o_res.count)
    );

endmodule
`default_nettype wire

FILE: src/rrl_ctrl.sv
// Sequencer for the ring list: decodes a request and steps the datapath.
`default_nettype none
module rrl_ctrl
    import rrl_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [CMD_W-1:0]  i_cmd,
    input  t_sts             i_sts,
    output t_ctl             o_ctl
);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic   r_ok, n_ok;

    // State and request registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= CMD_ADD;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_ok    <= n_ok;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_cmd           = r_cmd;
        n_ok            = r_ok;
        o_ready         = 1'b0;
        o_ctl.item_load = 1'b0;
        o_ctl.rd_en     = 1'b0;
        o_ctl.rd_sel    = RD_CUR;
        o_ctl.op        = DP_NOP;
        o_ctl.res_load  = 1'b0;
        o_ctl.res_ok    = r_ok;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.item_load = 1'b1;
                    n_cmd           = t_cmd'(i_cmd);
                    n_state         = ST_DISPATCH;
                end
            end

            // Read the current slot for every path and pick the operation
            ST_DISPATCH: begin
                o_ctl.rd_en = 1'b1;
                o_ctl.op    = DP_WALK_INIT;
                n_ok        = 1'b0;
                n_state     = ST_DONE;
                priority case (r_cmd)
                    CMD_ADD: begin
                        if (!i_sts.item_zero && !i_sts.full) n_state = ST_ADD_NEW;
                    end
                    CMD_DELETE: begin
                        if (!i_sts.count_zero) n_state = ST_DEL_START;
                    end
                    CMD_REMOVE: begin
                        if (!i_sts.count_zero && !i_sts.item_zero) n_state = ST_WALK;
                    end
                    CMD_FIND: begin
                        if (!i_sts.count_zero) n_state = ST_WALK;
                    end
                    CMD_NEXT: begin
                        if (!i_sts.count_zero) n_state = ST_NEXT_STEP;
                    end
                    default: n_state = ST_DONE;
                endcase
            end

            // Write the new slot, then splice it in after the current one
            ST_ADD_NEW: begin
                o_ctl.op = DP_ADD_NEW;
                n_state  = ST_ADD_LINK;
            end
            ST_ADD_LINK: begin
                o_ctl.op = DP_ADD_LINK;
                n_ok     = 1'b1;
                n_state  = ST_FETCH;
            end

            // Drop a lone entry, or fetch the next one to copy over the current
            ST_DEL_START: begin
                n_ok = 1'b1;
                if (i_sts.count_one) begin
                    o_ctl.op = DP_DEL_ONE;
                    n_state  = ST_DONE;
                end else begin
                    o_ctl.op     = DP_DEL_GONE;
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_LINK;
                    n_state      = ST_DEL_COPY;
                end
            end
            ST_DEL_COPY: begin
                o_ctl.op = DP_DEL_COPY;
                n_state  = ST_FETCH;
            end

            // One link per cycle until a match or back at the start
            ST_WALK: begin
                if (i_sts.match) begin
                    n_ok    = 1'b1;
                    n_state = (r_cmd == CMD_REMOVE) ? ST_DEL_START : ST_DONE;
                end else begin
                    o_ctl.op     = DP_STEP;
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_LINK;
                    if (i_sts.walk_last) begin
                        n_ok    = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end

            ST_NEXT_STEP: begin
                o_ctl.op     = DP_STEP;
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = RD_LINK;
                n_ok         = 1'b1;
                n_state      = ST_DONE;
            end

            ST_FETCH: begin
                o_ctl.rd_en = 1'b1;
                n_state     = ST_DONE;
            end

            // Hold until the result register is free
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/rrl_dp.sv
// Datapath of the ring list: slot memories, free map, current slot and result register.
`default_nettype none
module rrl_dp
    import rrl_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_ctl               i_ctl,
    output t_sts               o_sts,
    input  wire [ITEM_W-1:0]   i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output logic               o_ok,
    output logic [ITEM_W-1:0]  o_data,
    output logic [COUNT_W-1:0] o_count
);

    logic [WORD_BITS-1:0] word_mem [CAPACITY];
    logic [SLOT_BITS-1:0] link_mem [CAPACITY];

    logic [WORD_BITS-1:0] r_item;
    logic [WORD_BITS-1:0] r_rd_word;
    logic [SLOT_BITS-1:0] r_rd_link;
    logic [SLOT_BITS-1:0] r_cur;
    logic [SLOT_BITS-1:0] r_aux;
    logic [CAPACITY-1:0]  r_free;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  r_walk;

    logic                 r_out_valid;
    logic                 r_out_ok;
    logic [ITEM_W-1:0]    r_out_data;
    logic [COUNT_W-1:0]   r_out_count;

    logic [SLOT_BITS-1:0] free_slot;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 word_we;
    logic [SLOT_BITS-1:0] word_waddr;
    logic [WORD_BITS-1:0] word_wdata;
    logic                 link_we;
    logic [SLOT_BITS-1:0] link_waddr;
    logic [SLOT_BITS-1:0] link_wdata;

    // Lowest numbered free slot
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) free_slot = SLOT_BITS'(i);
        end
    end

    assign rd_addr = (i_ctl.rd_sel == RD_LINK) ? r_rd_link : r_cur;

    // Memory write port selection
    always_comb begin
        word_we    = 1'b0;
        word_waddr = r_cur;
        word_wdata = r_rd_word;
        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = r_rd_link;
        unique case (i_ctl.op)
            DP_ADD_NEW: begin
                word_we    = 1'b1;
                word_waddr = free_slot;
                word_wdata = r_item;
                link_we    = 1'b1;
                link_waddr = free_slot;
                link_wdata = (r_count == '0) ? free_slot : r_rd_link;
            end
            DP_ADD_LINK: begin
                link_we    = (r_count != '0);
                link_wdata = r_aux;
            end
            DP_DEL_COPY: begin
                word_we = 1'b1;
                link_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Slot memories with registered read
    always_ff @(posedge i_clk) begin
        if (word_we) word_mem[word_waddr] <= word_wdata;
        if (link_we) link_mem[link_waddr] <= link_wdata;
        if (i_ctl.rd_en) begin
            r_rd_word <= word_mem[rd_addr];
            r_rd_link <= link_mem[rd_addr];
        end
        if (i_ctl.item_load) r_item <= i_item[WORD_BITS-1:0];
    end

    // List control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_aux   <= '0;
            r_free  <= '1;
            r_count <= '0;
            r_walk  <= '0;
        end else begin
            unique case (i_ctl.op)
                DP_WALK_INIT: r_walk <= r_count;
                DP_ADD_NEW:   r_aux  <= free_slot;
                DP_ADD_LINK: begin
                    r_cur         <= r_aux;
                    r_free[r_aux] <= 1'b0;
                    r_count       <= r_count + 1'b1;
                end
                DP_DEL_ONE: begin
                    r_free[r_cur] <= 1'b1;
                    r_cur         <= '0;
                    r_count       <= r_count - 1'b1;
                end
                DP_DEL_GONE:  r_aux <= r_rd_link;
                DP_DEL_COPY: begin
                    r_free[r_aux] <= 1'b1;
                    r_count       <= r_count - 1'b1;
                end
                DP_STEP: begin
                    r_cur  <= r_rd_link;
                    r_walk <= r_walk - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: load on request, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_out_ok    <= i_ctl.res_ok;
            r_out_data  <= (r_count != '0) ? ITEM_W'(r_rd_word) : '0;
            r_out_count <= COUNT_W'(r_count);
        end
    end

    // Status back to the controller
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_one  = (r_count == CNT_BITS'(1));
    assign o_sts.full       = (r_count >= CNT_BITS'(CAPACITY));
    assign o_sts.item_zero  = (r_item == '0);
    assign o_sts.match      = (r_rd_word == r_item);
    assign o_sts.walk_last  = (r_walk == CNT_BITS'(1));
    assign o_sts.out_free   = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_ok    = r_out_ok;
    assign o_data  = r_out_data;
    assign o_count = r_out_count;

endmodule
`default_nettype wire
